/* rtl/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16LE transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    // depth of the job queue between decoder and unit emitter
    localparam int unsigned JOB_QUEUE_DEPTH = 4;

    // replacement character for malformed input
    localparam logic [15:0] REPL_CHAR = 16'hFFFD;

    // one decoded input byte: replacement units first, then up to two units
    typedef struct packed {
        logic [2:0]  repl_cnt;   // number of U+FFFD units, 0 to 4
        logic [1:0]  unit_cnt;   // number of real units after them, 0 to 2
        logic [15:0] unit0;      // single unit or high surrogate
        logic [15:0] unit1;      // low surrogate
        logic        last;       // request carried the end-of-string flag
    } job_t;

endpackage

/* rtl/u8u16_byte_if.sv */
// ----------------------------------------------------------------------------
// u8u16_byte_if
// Input channel: one UTF-8 byte per request, with end-of-string flag.
// ----------------------------------------------------------------------------
interface u8u16_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);

endinterface

/* rtl/u8u16_unit_if.sv */
// ----------------------------------------------------------------------------
// u8u16_unit_if
// Output channel: one UTF-16 code unit per request, with marker flags.
// ----------------------------------------------------------------------------
interface u8u16_unit_if;

    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        replaced;
    logic        run_last;
    logic        string_end;

    modport source (output valid, output code_unit, output replaced,
                    output run_last, output string_end, input ready);
    modport sink   (input valid, input code_unit, input replaced,
                    input run_last, input string_end, output ready);

endinterface

/* rtl/u8u16_front.sv */
// ----------------------------------------------------------------------------
// u8u16_front
// UTF-8 decoder: takes one byte per cycle while the job queue has room, tracks
// the pending sequence and produces a job for each byte that causes code units.
// ----------------------------------------------------------------------------
module u8u16_front (
    input  logic                 clk,
    input  logic                 rst_n,
    u8u16_byte_if.sink           byte_ch,
    output logic                 job_valid,
    output u8u16_pkg::job_t      job,
    input  logic                 job_ready
);

    import u8u16_pkg::*;

    typedef enum logic [2:0] {
        LEAD_ASCII,
        LEAD_TWO,
        LEAD_THREE,
        LEAD_FOUR,
        LEAD_BAD
    } lead_kind_t;

    localparam logic [7:0] LEAD_E0   = 8'hE0;
    localparam logic [7:0] LEAD_ED   = 8'hED;
    localparam logic [7:0] LEAD_F0   = 8'hF0;
    localparam logic [7:0] LEAD_F4   = 8'hF4;
    localparam logic [7:0] LIMIT_A0  = 8'hA0;
    localparam logic [7:0] LIMIT_90  = 8'h90;
    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [15:0] HI_SURR   = 16'hD800;
    localparam logic [15:0] LO_SURR   = 16'hDC00;

    logic [7:0]  pending_lead_reg, pending_lead_next;
    logic [2:0]  exp_len_reg, exp_len_next;
    logic [2:0]  seen_reg, seen_next;
    logic [20:0] acc_reg, acc_next;
    logic        sec_ok_reg, sec_ok_next;

    logic        accept;
    logic [7:0]  b;
    logic        last;
    logic        is_cont;
    lead_kind_t  lead_kind;
    logic [2:0]  seen_inc;
    logic [20:0] acc_shift;
    logic [20:0] cp_off;
    logic        sec_bad;
    logic        sec_ok_upd;

    assign byte_ch.ready = job_ready;
    assign accept        = byte_ch.valid && job_ready;
    assign b             = byte_ch.in_byte;
    assign last          = byte_ch.last_byte;
    assign is_cont       = (b[7:6] == 2'b10);

    // classify the byte as a lead
    always_comb
    begin
        priority if (b < 8'h80)
            lead_kind = LEAD_ASCII;
        else if (b >= 8'hC2 && b <= 8'hDF)
            lead_kind = LEAD_TWO;
        else if (b >= 8'hE0 && b <= 8'hEF)
            lead_kind = LEAD_THREE;
        else if (b >= 8'hF0 && b <= 8'hF4)
            lead_kind = LEAD_FOUR;
        else
            lead_kind = LEAD_BAD;
    end

    // continuation arithmetic
    assign seen_inc  = seen_reg + 3'd1;
    assign acc_shift = {acc_reg[14:0], b[5:0]};
    assign cp_off    = acc_shift - SUPP_BASE;
    assign sec_bad   = (pending_lead_reg == LEAD_E0 && b <  LIMIT_A0) ||
                       (pending_lead_reg == LEAD_ED && b >= LIMIT_A0) ||
                       (pending_lead_reg == LEAD_F0 && b <  LIMIT_90) ||
                       (pending_lead_reg == LEAD_F4 && b >= LIMIT_90);
    assign sec_ok_upd = sec_ok_reg && !(seen_reg == 3'd1 && sec_bad);

    // next decoder state and job for this byte
    always_comb
    begin
        logic do_lead;
        logic go_idle;
        do_lead           = 1'b0;
        go_idle           = 1'b0;
        pending_lead_next = pending_lead_reg;
        exp_len_next      = exp_len_reg;
        seen_next         = seen_reg;
        acc_next          = acc_reg;
        sec_ok_next       = sec_ok_reg;
        job               = '0;
        job.last          = last;

        if (exp_len_reg != 3'd0)
        begin
            if (is_cont)
            begin
                if (seen_inc >= exp_len_reg)
                begin
                    if (sec_ok_upd)
                    begin
                        if (acc_shift[20:16] == 5'd0)
                        begin
                            job.unit_cnt = 2'd1;
                            job.unit0    = acc_shift[15:0];
                        end
                        else
                        begin
                            job.unit_cnt = 2'd2;
                            job.unit0    = HI_SURR + {6'd0, cp_off[19:10]};
                            job.unit1    = LO_SURR + {6'd0, cp_off[9:0]};
                        end
                    end
                    else
                    begin
                        job.repl_cnt = exp_len_reg;
                    end
                    go_idle = 1'b1;
                end
                else if (last)
                begin
                    job.repl_cnt = seen_inc;
                    go_idle      = 1'b1;
                end
                else
                begin
                    seen_next   = seen_inc;
                    acc_next    = acc_shift;
                    sec_ok_next = sec_ok_upd;
                end
            end
            else
            begin
                // broken sequence: flush pending bytes, then decode as lead
                job.repl_cnt = seen_reg;
                go_idle      = 1'b1;
                do_lead      = 1'b1;
            end
        end
        else
        begin
            do_lead = 1'b1;
        end

        if (go_idle)
        begin
            pending_lead_next = 8'd0;
            exp_len_next      = 3'd0;
            seen_next         = 3'd0;
            acc_next          = 21'd0;
            sec_ok_next       = 1'b1;
        end

        if (do_lead)
        begin
            unique case (lead_kind)
                LEAD_ASCII:
                begin
                    job.unit_cnt = 2'd1;
                    job.unit0    = {8'd0, b};
                end
                LEAD_BAD:
                begin
                    job.repl_cnt = job.repl_cnt + 3'd1;
                end
                LEAD_TWO, LEAD_THREE, LEAD_FOUR:
                begin
                    if (last)
                    begin
                        job.repl_cnt = job.repl_cnt + 3'd1;
                    end
                    else
                    begin
                        pending_lead_next = b;
                        seen_next         = 3'd1;
                        sec_ok_next       = 1'b1;
                        unique case (lead_kind)
                            LEAD_TWO:
                            begin
                                exp_len_next = 3'd2;
                                acc_next     = {16'd0, b[4:0]};
                            end
                            LEAD_THREE:
                            begin
                                exp_len_next = 3'd3;
                                acc_next     = {17'd0, b[3:0]};
                            end
                            default:
                            begin
                                exp_len_next = 3'd4;
                                acc_next     = {18'd0, b[2:0]};
                            end
                        endcase
                    end
                end
                default:
                begin
                    job.repl_cnt = job.repl_cnt + 3'd1;
                end
            endcase
        end

        // end of string always returns to idle
        if (last)
        begin
            pending_lead_next = 8'd0;
            exp_len_next      = 3'd0;
            seen_next         = 3'd0;
            acc_next          = 21'd0;
            sec_ok_next       = 1'b1;
        end
    end

    assign job_valid = accept && (job.repl_cnt != 3'd0 || job.unit_cnt != 2'd0);

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_lead_reg <= 8'd0;
            exp_len_reg      <= 3'd0;
            seen_reg         <= 3'd0;
            acc_reg          <= 21'd0;
            sec_ok_reg       <= 1'b1;
        end
        else if (accept)
        begin
            pending_lead_reg <= pending_lead_next;
            exp_len_reg      <= exp_len_next;
            seen_reg         <= seen_next;
            acc_reg          <= acc_next;
            sec_ok_reg       <= sec_ok_next;
        end
    end

endmodule

/* rtl/u8u16_fifo.sv */
// ----------------------------------------------------------------------------
// u8u16_fifo
// Small job queue between decoder and unit emitter.
// ----------------------------------------------------------------------------
module u8u16_fifo #(
    parameter int unsigned DEPTH = u8u16_pkg::JOB_QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  u8u16_pkg::job_t  wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output u8u16_pkg::job_t  rd_data
);

    import u8u16_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = store_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

/* rtl/u8u16_back.sv */
// ----------------------------------------------------------------------------
// u8u16_back
// Unit emitter: walks the head job one code unit per cycle, while the output
// is free, into an output register and pops the job with its final unit.
// ----------------------------------------------------------------------------
module u8u16_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  u8u16_pkg::job_t   job,
    output logic              job_pop,
    u8u16_unit_if.source      unit_ch
);

    import u8u16_pkg::*;

    logic [1:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] code_unit_reg;
    logic        replaced_reg;
    logic        run_last_reg;
    logic        string_end_reg;

    logic        out_free;
    logic        emit;
    logic [2:0]  pos;
    logic [2:0]  total;
    logic [2:0]  real_pos;
    logic        in_repl;
    logic        final_unit;
    logic [15:0] sel_unit;

    assign out_free   = !out_valid_reg || unit_ch.ready;
    assign emit       = job_valid && out_free;
    assign pos        = {1'b0, idx_reg};
    assign total      = job.repl_cnt + {1'b0, job.unit_cnt};
    assign real_pos   = pos - job.repl_cnt;
    assign in_repl    = pos < job.repl_cnt;
    assign final_unit = (pos + 3'd1) == total;
    assign sel_unit   = in_repl ? REPL_CHAR :
                        (real_pos == 3'd0) ? job.unit0 : job.unit1;
    assign job_pop    = emit && final_unit;

    // unit index within the head job and output valid
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            idx_next       = final_unit ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (unit_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            code_unit_reg  <= sel_unit;
            replaced_reg   <= in_repl;
            run_last_reg   <= final_unit;
            string_end_reg <= final_unit && job.last;
        end
    end

    assign unit_ch.valid      = out_valid_reg;
    assign unit_ch.code_unit  = code_unit_reg;
    assign unit_ch.replaced   = replaced_reg;
    assign unit_ch.run_last   = run_last_reg;
    assign unit_ch.string_end = string_end_reg;

endmodule

/* rtl/utf8_to_utf16le_transcoder.sv */
// ----------------------------------------------------------------------------
// utf8_to_utf16le_transcoder
// UTF-8 byte stream in, UTF-16 code units out (low byte first downstream).
// ----------------------------------------------------------------------------
// Usage:
//   byte_ch takes one UTF-8 byte per request; last_byte marks the final byte
//   of a string and flushes an incomplete sequence as U+FFFD units.
//   unit_ch gives one UTF-16 code unit per request; run_last flags the last
//   unit caused by an input byte, string_end the last unit of the string.
//   A byte causes zero to four units (surrogate pairs or replacements).
// Timing:
//   A byte is accepted every cycle while the job queue has room; its units
//   reach unit_ch via the queue and output register. The emitter sends one
//   unit per cycle unless unit_ch stalls, so sustained input rate is one byte
//   per cycle when each byte yields at most one unit on average; bursts queue.
// Reset:
//   rst_n clears the decoder to idle, empties the queue and drops the
//   output register.
// Stall:
//   when unit_ch.ready is low the output unit holds, the queue fills and
//   byte_ch.ready falls once the queue is full.
// ----------------------------------------------------------------------------
module utf8_to_utf16le_transcoder #(
    parameter int unsigned JOB_QUEUE_DEPTH = u8u16_pkg::JOB_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    u8u16_byte_if.sink    byte_ch,
    u8u16_unit_if.source  unit_ch
);

    import u8u16_pkg::*;

    logic front_valid;
    logic front_ready;
    job_t front_job;
    logic head_valid;
    logic head_pop;
    job_t head_job;

    // decoder
    u8u16_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .job_valid (front_valid),
        .job       (front_job),
        .job_ready (front_ready)
    );

    // job queue
    u8u16_fifo #(
        .DEPTH (JOB_QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_job),
        .rd_valid (head_valid),
        .rd_ready (head_pop),
        .rd_data  (head_job)
    );

    // unit emitter
    u8u16_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (head_valid),
        .job       (head_job),
        .job_pop   (head_pop),
        .unit_ch   (unit_ch)
    );

endmodule
